/* rtl/fpl_pkg.sv */
package fpl_pkg;

   // configuration port address width, registers at byte address 4*i
   localparam int CSR_ADDR_BITS = 5;

   // register indexes
   typedef enum logic [2:0] {
      REG_STAGE_GAIN    = 3'd0,
      REG_FEEDBACK_GAIN = 3'd1,
      REG_DRIVE_GAIN    = 3'd2,
      REG_HP_ENABLE     = 3'd3,
      REG_HP_GAIN       = 3'd4
   } reg_index_type;

   // register reset values
   localparam logic [17:0] STAGE_GAIN_RESET    = 18'd0;
   localparam logic [16:0] FEEDBACK_GAIN_RESET = 17'd0;
   localparam logic [15:0] DRIVE_GAIN_RESET    = 16'd4096;
   localparam logic [17:0] HP_GAIN_RESET       = 18'd0;

   // drive of exactly 1.0 in Q4.12, anything above enables the soft clip
   localparam logic [15:0] DRIVE_UNITY = 16'd4096;

   // largest tanh table value, Q1.23
   localparam logic [23:0] CLIP_MAX = 24'h7FFFFF;

   // pole selector: ladder stages 0 to 3 and the high-pass pre-stage
   localparam logic [2:0] POLE_FIRST = 3'd0;
   localparam logic [2:0] POLE_LAST  = 3'd3;
   localparam logic [2:0] POLE_HP    = 3'd4;

   // arithmetic right shift applied to the shared product
   typedef enum logic [2:0] {
      SH_0  = 3'd0,
      SH_12 = 3'd1,
      SH_15 = 3'd2,
      SH_18 = 3'd3,
      SH_30 = 3'd4
   } shift_type;

   // one operation for the shared multiplier
   typedef struct packed {
      logic signed [32:0] op_a;
      logic signed [30:0] op_b;
      shift_type          shift;
   } mul_cmd_type;

   // clamp to the signed 32-bit Q4.27 range
   function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
      if (v > 64'sd2147483647) begin
         return 32'sh7FFFFFFF;
      end else if (v < -64'sd2147483648) begin
         return 32'sh80000000;
      end
      return v[31:0];
   endfunction

endpackage

/* rtl/fpl_stream_if.sv */
// input item channel
interface fpl_req_if #(parameter int SAMPLE_BITS = 24);
   logic                          valid;
   logic                          ready;
   logic signed [SAMPLE_BITS-1:0] audio_in;
   logic                          block_end;

   modport source (output valid, output audio_in, output block_end, input ready);
   modport sink   (input valid, input audio_in, input block_end, output ready);
endinterface

// result item channel
interface fpl_rsp_if #(parameter int SAMPLE_BITS = 24);
   logic                          valid;
   logic                          ready;
   logic signed [SAMPLE_BITS-1:0] audio_out;
   logic                          block_end_out;

   modport source (output valid, output audio_out, output block_end_out, input ready);
   modport sink   (input valid, input audio_out, input block_end_out, output ready);
endinterface

/* rtl/fpl_mul_unit.sv */
module fpl_mul_unit
   import fpl_pkg::*;
(
   input  logic               clock,
   input  mul_cmd_type        cmd,
   output logic signed [63:0] shifted
);

   logic signed [63:0] prod_ff;
   logic signed [63:0] prod_in;
   shift_type          shift_ff;
   shift_type          shift_in;

   // signed 33 x 31 product, registered with its shift
   always_comb begin
      prod_in  = cmd.op_a * cmd.op_b;
      shift_in = cmd.shift;
   end

   always_ff @(posedge clock) begin
      prod_ff  <= prod_in;
      shift_ff <= shift_in;
   end

   // floor shift back to the operand format
   always_comb begin
      case (shift_ff)
         SH_0:    shifted = prod_ff;
         SH_12:   shifted = prod_ff >>> 12;
         SH_15:   shifted = prod_ff >>> 15;
         SH_18:   shifted = prod_ff >>> 18;
         SH_30:   shifted = prod_ff >>> 30;
         default: shifted = prod_ff;
      endcase
   end

endmodule

/* rtl/fpl_clip_rom.sv */
module fpl_clip_rom
   import fpl_pkg::*;
#(
   parameter int CLIP_TABLE_DEPTH = 256
)
(
   input  logic                                clock,
   input  logic [$clog2(CLIP_TABLE_DEPTH)-1:0] rd_addr,
   output logic [23:0]                         rd_data
);

   localparam longint Q31_ONE = 64'sd2147483648;

   // quotient of non-negative values, shift and subtract
   function automatic longint udiv(input longint n, input longint d);
      longint q;
      longint r;
      q = 0;
      r = 0;
      for (int b = 62; b >= 0; b--) begin
         r = (r <<< 1) | ((n >>> b) & 64'sd1);
         if (r >= d) begin
            r = r - d;
            q = q | (64'sd1 <<< b);
         end
      end
      return q;
   endfunction

   // e^-f for f in Q.31 between 0 and 1, series to twenty terms
   function automatic longint exp_neg_frac(input longint f);
      longint sum;
      longint term;
      sum  = Q31_ONE;
      term = Q31_ONE;
      for (int k = 1; k <= 20; k++) begin
         term = udiv((term * f) >>> 31, longint'(k));
         if ((k & 1) != 0) begin
            sum = sum - term;
         end else begin
            sum = sum + term;
         end
      end
      return sum;
   endfunction

   // entry i holds tanh(8*i/depth) in Q1.23, worked out at elaboration
   function automatic logic [23:0] tanh_entry(input int idx);
      longint e1;
      longint num;
      longint n;
      longint f;
      longint e;
      longint t;
      e1  = exp_neg_frac(Q31_ONE);
      num = 64'(16) * longint'(idx);
      n   = udiv(num, longint'(CLIP_TABLE_DEPTH));
      f   = udiv((num - n * longint'(CLIP_TABLE_DEPTH)) <<< 31, longint'(CLIP_TABLE_DEPTH));
      e   = exp_neg_frac(f);
      for (longint j = 0; j < n; j++) begin
         e = (e * e1) >>> 31;
      end
      t = udiv(((Q31_ONE - e) <<< 23) + ((Q31_ONE + e) >>> 1), Q31_ONE + e);
      if (t > longint'(CLIP_MAX)) begin
         t = longint'(CLIP_MAX);
      end
      return t[23:0];
   endfunction

   logic [23:0] rom [CLIP_TABLE_DEPTH];
   logic [23:0] rd_data_ff;
   logic [23:0] rd_data_in;

   // constant contents
   for (genvar i = 0; i < CLIP_TABLE_DEPTH; i++) begin : g_rom
      localparam logic [23:0] ENTRY = tanh_entry(i);
      assign rom[i] = ENTRY;
   end

   // registered read
   assign rd_data_in = rom[rd_addr];

   always_ff @(posedge clock) begin
      rd_data_ff <= rd_data_in;
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/four_pole_ladder_lowpass.sv */
// channel  | interface            | direction | payload
// req_port | fpl_req_if.sink      | in        | audio_in, block_end
// rsp_port | fpl_rsp_if.source    | out       | audio_out, block_end_out
// csr_*    | register write/read  | in/out    | gains, high-pass enable
//
// the result register loads after the steps in order: high-pass stage if enabled,
// drive, the interpolated clip when it runs, feedback, the four poles; input
// reopens as the result loads; every product uses the single shared multiplier in turn
// reset is synchronous; it clears the integrators and loads register defaults
// a result waits in the output register; a stalled sink holds the next item
// in its final step and input stays not ready until that item moves out
module four_pole_ladder_lowpass
   import fpl_pkg::*;
#(
   parameter int SAMPLE_BITS      = 24,
   parameter int CLIP_TABLE_DEPTH = 256
)
(
   input  logic                     clock,
   input  logic                     reset,
   fpl_req_if.sink                  req_port,
   fpl_rsp_if.source                rsp_port,
   input  logic                     csr_psel,
   input  logic                     csr_penable,
   input  logic                     csr_pwrite,
   input  logic [CSR_ADDR_BITS-1:0] csr_paddr,
   input  logic [31:0]              csr_pwdata,
   output logic [31:0]              csr_prdata,
   output logic                     csr_pready
);

   localparam int ADDR_W = $clog2(CLIP_TABLE_DEPTH);
   localparam int SHL    = (SAMPLE_BITS <= 28) ? 28 - SAMPLE_BITS : 0;
   localparam int SHR    = (SAMPLE_BITS > 28) ? SAMPLE_BITS - 28 : 0;
   localparam logic signed [63:0] OUT_MAX = (64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1;
   localparam logic signed [63:0] OUT_MIN = -(64'sd1 <<< (SAMPLE_BITS - 1));
   localparam logic [ADDR_W-1:0]  IDX_LAST = ADDR_W'(CLIP_TABLE_DEPTH - 1);
   localparam logic signed [31:0] CLIP_RAIL = {4'b0, CLIP_MAX, 4'b0};

   typedef enum logic [13:0] {
      S_IDLE      = 14'h0001,
      S_POLE_MUL  = 14'h0002,
      S_POLE_SUM  = 14'h0004,
      S_POLE_UPD  = 14'h0008,
      S_DRV_MUL   = 14'h0010,
      S_DRV_CHK   = 14'h0020,
      S_CLIP_POS  = 14'h0040,
      S_CLIP_ADDR = 14'h0080,
      S_CLIP_LO   = 14'h0100,
      S_CLIP_HI   = 14'h0200,
      S_CLIP_SUM  = 14'h0400,
      S_FB_MUL    = 14'h0800,
      S_FB_SUB    = 14'h1000,
      S_DONE      = 14'h2000
   } state_type;

   // control and configuration registers
   state_type   state_ff, state_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [17:0] stage_gain_ff, stage_gain_in;
   logic [16:0] feedback_gain_ff, feedback_gain_in;
   logic [15:0] drive_gain_ff, drive_gain_in;
   logic        hp_enable_ff, hp_enable_in;
   logic [17:0] hp_gain_ff, hp_gain_in;
   logic signed [31:0] lad_st_ff [4];
   logic signed [31:0] lad_st_in [4];
   logic signed [31:0] hp_st_ff, hp_st_in;

   // working registers
   logic signed [31:0]     x_ff, x_in;
   logic signed [31:0]     v_ff, v_in;
   logic signed [31:0]     lp_ff, lp_in;
   logic [2:0]             pole_ff, pole_in;
   logic [29:0]            mag_ff, mag_in;
   logic                   sign_ff, sign_in;
   logic [ADDR_W-1:0]      idx_ff, idx_in;
   logic [29:0]            fr_ff, fr_in;
   logic [23:0]            lo_ff, lo_in;
   logic                   be_ff, be_in;
   logic [SAMPLE_BITS-1:0] rsp_audio_ff, rsp_audio_in;
   logic                   rsp_be_ff, rsp_be_in;

   // shared units
   mul_cmd_type        mul_cmd;
   logic signed [63:0] mul_shifted;
   logic [ADDR_W-1:0]  rom_addr;
   logic [23:0]        rom_data;

   // datapath terms
   logic signed [63:0] in_scaled;
   logic signed [31:0] st_sel;
   logic [17:0]        pole_gain;
   logic signed [32:0] pole_diff;
   logic signed [31:0] mul_sat;
   logic signed [31:0] lp_sum;
   logic signed [31:0] st_upd;
   logic signed [31:0] hp_out;
   logic               drv_neg;
   logic [32:0]        drv_mag;
   logic               clip_big;
   logic signed [31:0] clip_rail;
   logic               idx_last;
   logic [23:0]        clip_hi;
   logic signed [24:0] clip_diff;
   logic signed [25:0] clip_sum;
   logic signed [31:0] clip_q27;
   logic signed [31:0] fb_out;
   logic signed [63:0] out_scaled;
   logic [SAMPLE_BITS-1:0] out_sat;
   logic               req_take;
   logic               cfg_wr;

   fpl_mul_unit u_mul (
      .clock   (clock),
      .cmd     (mul_cmd),
      .shifted (mul_shifted)
   );

   fpl_clip_rom #(
      .CLIP_TABLE_DEPTH (CLIP_TABLE_DEPTH)
   ) u_clip_rom (
      .clock   (clock),
      .rd_addr (rom_addr),
      .rd_data (rom_data)
   );

   // handshakes
   assign req_port.ready         = (state_ff == S_IDLE);
   assign req_take               = req_port.valid && (state_ff == S_IDLE);
   assign rsp_port.valid         = rsp_valid_ff;
   assign rsp_port.audio_out     = rsp_audio_ff;
   assign rsp_port.block_end_out = rsp_be_ff;

   // input sample to Q4.27
   assign in_scaled = (64'(req_port.audio_in) <<< SHL) >>> SHR;

   // one-pole terms
   assign st_sel    = (pole_ff == POLE_HP) ? hp_st_ff : lad_st_ff[pole_ff[1:0]];
   assign pole_gain = (pole_ff == POLE_HP) ? hp_gain_ff : stage_gain_ff;
   assign pole_diff = 33'(x_ff) - 33'(st_sel);
   assign mul_sat   = sat32(mul_shifted);
   assign lp_sum    = sat32(64'(mul_sat) + 64'(st_sel));
   assign st_upd    = sat32(64'(lp_ff) + 64'(v_ff));
   assign hp_out    = sat32(64'(x_ff) - 64'(lp_ff));

   // drive magnitude and clip rail
   assign drv_neg   = mul_sat[31];
   assign drv_mag   = drv_neg ? -33'(mul_sat) : 33'(mul_sat);
   assign clip_big  = (drv_mag[32:30] != 3'd0);
   assign clip_rail = drv_neg ? -CLIP_RAIL : CLIP_RAIL;

   // table interpolation, the entry past the end reads as the rail
   assign idx_last  = (idx_ff == IDX_LAST);
   assign clip_hi   = idx_last ? CLIP_MAX : rom_data;
   assign clip_diff = signed'({1'b0, clip_hi}) - signed'({1'b0, lo_ff});
   assign clip_sum  = signed'({2'b0, lo_ff}) + signed'(mul_shifted[25:0]);
   assign clip_q27  = sign_ff ? -(32'(clip_sum) <<< 4) : (32'(clip_sum) <<< 4);

   // feedback subtraction on the unclamped product
   assign fb_out = sat32(64'(x_ff) - mul_shifted);

   // fourth stage back to the sample format, saturated
   assign out_scaled = (64'(x_ff) <<< SHR) >>> SHL;
   always_comb begin
      if (out_scaled > OUT_MAX) begin
         out_sat = SAMPLE_BITS'(OUT_MAX);
      end else if (out_scaled < OUT_MIN) begin
         out_sat = SAMPLE_BITS'(OUT_MIN);
      end else begin
         out_sat = out_scaled[SAMPLE_BITS-1:0];
      end
   end

   // sequencer and multiplier operand selection
   always_comb begin
      state_in     = state_ff;
      x_in         = x_ff;
      v_in         = v_ff;
      lp_in        = lp_ff;
      pole_in      = pole_ff;
      mag_in       = mag_ff;
      sign_in      = sign_ff;
      idx_in       = idx_ff;
      fr_in        = fr_ff;
      lo_in        = lo_ff;
      be_in        = be_ff;
      lad_st_in    = lad_st_ff;
      hp_st_in     = hp_st_ff;
      rsp_audio_in = rsp_audio_ff;
      rsp_be_in    = rsp_be_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_port.ready;
      rom_addr     = idx_ff;
      mul_cmd.op_a  = '0;
      mul_cmd.op_b  = '0;
      mul_cmd.shift = SH_0;

      case (state_ff)
         S_IDLE: begin
            if (req_take) begin
               x_in  = sat32(in_scaled);
               be_in = req_port.block_end;
               if (hp_enable_ff) begin
                  pole_in  = POLE_HP;
                  state_in = S_POLE_MUL;
               end else begin
                  state_in = S_DRV_MUL;
               end
            end
         end
         S_POLE_MUL: begin
            mul_cmd.op_a  = pole_diff;
            mul_cmd.op_b  = signed'({13'b0, pole_gain});
            mul_cmd.shift = SH_18;
            state_in      = S_POLE_SUM;
         end
         S_POLE_SUM: begin
            v_in     = mul_sat;
            lp_in    = lp_sum;
            state_in = S_POLE_UPD;
         end
         S_POLE_UPD: begin
            if (pole_ff == POLE_HP) begin
               hp_st_in = st_upd;
               x_in     = hp_out;
               state_in = S_DRV_MUL;
            end else begin
               lad_st_in[pole_ff[1:0]] = st_upd;
               x_in = lp_ff;
               if (pole_ff == POLE_LAST) begin
                  state_in = S_DONE;
               end else begin
                  pole_in  = pole_ff + 3'd1;
                  state_in = S_POLE_MUL;
               end
            end
         end
         S_DRV_MUL: begin
            mul_cmd.op_a  = 33'(x_ff);
            mul_cmd.op_b  = signed'({15'b0, drive_gain_ff});
            mul_cmd.shift = SH_12;
            state_in      = S_DRV_CHK;
         end
         S_DRV_CHK: begin
            if (drive_gain_ff <= DRIVE_UNITY) begin
               x_in     = mul_sat;
               state_in = S_FB_MUL;
            end else if (clip_big) begin
               x_in     = clip_rail;
               state_in = S_FB_MUL;
            end else begin
               mag_in   = drv_mag[29:0];
               sign_in  = drv_neg;
               state_in = S_CLIP_POS;
            end
         end
         S_CLIP_POS: begin
            mul_cmd.op_a  = signed'({3'b0, mag_ff});
            mul_cmd.op_b  = 31'(CLIP_TABLE_DEPTH);
            mul_cmd.shift = SH_0;
            state_in      = S_CLIP_ADDR;
         end
         S_CLIP_ADDR: begin
            rom_addr = mul_shifted[30 +: ADDR_W];
            idx_in   = mul_shifted[30 +: ADDR_W];
            fr_in    = mul_shifted[29:0];
            state_in = S_CLIP_LO;
         end
         S_CLIP_LO: begin
            lo_in    = rom_data;
            rom_addr = idx_last ? idx_ff : idx_ff + ADDR_W'(1);
            state_in = S_CLIP_HI;
         end
         S_CLIP_HI: begin
            mul_cmd.op_a  = 33'(clip_diff);
            mul_cmd.op_b  = signed'({1'b0, fr_ff});
            mul_cmd.shift = SH_30;
            state_in      = S_CLIP_SUM;
         end
         S_CLIP_SUM: begin
            x_in     = clip_q27;
            state_in = S_FB_MUL;
         end
         S_FB_MUL: begin
            mul_cmd.op_a  = 33'(lad_st_ff[3]);
            mul_cmd.op_b  = signed'({14'b0, feedback_gain_ff});
            mul_cmd.shift = SH_15;
            state_in      = S_FB_SUB;
         end
         S_FB_SUB: begin
            x_in     = fb_out;
            pole_in  = POLE_FIRST;
            state_in = S_POLE_MUL;
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_port.ready) begin
               rsp_audio_in = out_sat;
               rsp_be_in    = be_ff;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // register writes and reads
   assign cfg_wr     = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;

   always_comb begin
      stage_gain_in    = stage_gain_ff;
      feedback_gain_in = feedback_gain_ff;
      drive_gain_in    = drive_gain_ff;
      hp_enable_in     = hp_enable_ff;
      hp_gain_in       = hp_gain_ff;
      if (cfg_wr) begin
         case (csr_paddr[4:2])
            REG_STAGE_GAIN:    stage_gain_in    = csr_pwdata[17:0];
            REG_FEEDBACK_GAIN: feedback_gain_in = csr_pwdata[16:0];
            REG_DRIVE_GAIN:    drive_gain_in    = csr_pwdata[15:0];
            REG_HP_ENABLE:     hp_enable_in     = csr_pwdata[0];
            REG_HP_GAIN:       hp_gain_in       = csr_pwdata[17:0];
            default:           ;
         endcase
      end
   end

   always_comb begin
      case (csr_paddr[4:2])
         REG_STAGE_GAIN:    csr_prdata = {14'b0, stage_gain_ff};
         REG_FEEDBACK_GAIN: csr_prdata = {15'b0, feedback_gain_ff};
         REG_DRIVE_GAIN:    csr_prdata = {16'b0, drive_gain_ff};
         REG_HP_ENABLE:     csr_prdata = {31'b0, hp_enable_ff};
         REG_HP_GAIN:       csr_prdata = {14'b0, hp_gain_ff};
         default:           csr_prdata = '0;
      endcase
   end

   // control state, configuration and integrators
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= S_IDLE;
         rsp_valid_ff     <= 1'b0;
         stage_gain_ff    <= STAGE_GAIN_RESET;
         feedback_gain_ff <= FEEDBACK_GAIN_RESET;
         drive_gain_ff    <= DRIVE_GAIN_RESET;
         hp_enable_ff     <= 1'b0;
         hp_gain_ff       <= HP_GAIN_RESET;
         lad_st_ff        <= '{default: '0};
         hp_st_ff         <= '0;
      end else begin
         state_ff         <= state_in;
         rsp_valid_ff     <= rsp_valid_in;
         stage_gain_ff    <= stage_gain_in;
         feedback_gain_ff <= feedback_gain_in;
         drive_gain_ff    <= drive_gain_in;
         hp_enable_ff     <= hp_enable_in;
         hp_gain_ff       <= hp_gain_in;
         lad_st_ff        <= lad_st_in;
         hp_st_ff         <= hp_st_in;
      end
   end

   // working payload
   always_ff @(posedge clock) begin
      x_ff         <= x_in;
      v_ff         <= v_in;
      lp_ff        <= lp_in;
      pole_ff      <= pole_in;
      mag_ff       <= mag_in;
      sign_ff      <= sign_in;
      idx_ff       <= idx_in;
      fr_ff        <= fr_in;
      lo_ff        <= lo_in;
      be_ff        <= be_in;
      rsp_audio_ff <= rsp_audio_in;
      rsp_be_ff    <= rsp_be_in;
   end

endmodule

/* rtl/fpl_checker.sv */
module fpl_checker #(
   parameter int SAMPLE_BITS = 24
)
(
   input logic                   clock,
   input logic                   reset,
   input logic                   req_valid,
   input logic                   req_ready,
   input logic                   rsp_valid,
   input logic                   rsp_ready,
   input logic [SAMPLE_BITS-1:0] rsp_audio_out,
   input logic                   rsp_block_end_out
);

   // no result is offered straight out of reset
   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result offered after reset");

   // one item at a time: input closes once an item is taken
   a_busy_after_take: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("input still open after an item was taken");

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_audio_out)
         && $stable(rsp_block_end_out))
      else $error("stalled result changed");

   // a new result only comes out of a busy block
   a_rsp_from_work: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(!req_ready))
      else $error("result appeared while the block was idle");

endmodule

bind four_pole_ladder_lowpass fpl_checker #(
   .SAMPLE_BITS (SAMPLE_BITS)
) u_fpl_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_port.valid),
   .req_ready         (req_port.ready),
   .rsp_valid         (rsp_port.valid),
   .rsp_ready         (rsp_port.ready),
   .rsp_audio_out     (rsp_port.audio_out),
   .rsp_block_end_out (rsp_port.block_end_out)
);

/* test/tb.sv */
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import fpl_pkg::*;

   localparam int SAMPLE_BITS    = 24;
   localparam int CLIP_DEPTH     = 256;
   localparam int HALF_PERIOD    = 10;
   localparam int RESET_CYCLES   = 4;
   localparam int SETTLE_CYCLES  = 32;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int RANDOM_PHASES  = 6;
   localparam int PHASE_SAMPLES  = 100;
   localparam int REPORT_LIMIT   = 10;
   localparam int NUM_REGS       = REG_HP_GAIN + 1;
   localparam int LAST_REG_SLOT  = (1 << (CSR_ADDR_BITS - 2)) - 1;
   localparam int Q27_SHIFT      = 28 - SAMPLE_BITS;

   localparam longint FRAC31_ONE = 64'sd2147483648;
   localparam longint Q27_EIGHT  = 64'sd1073741824;
   localparam longint Q27_MAX    = 64'sd2147483647;
   localparam longint Q27_MIN    = -64'sd2147483648;
   localparam longint SAMPLE_MAX = (64'sd1 <<< (SAMPLE_BITS - 1)) - 1;
   localparam longint SAMPLE_MIN = -(64'sd1 <<< (SAMPLE_BITS - 1));

   typedef struct packed {
      logic signed [SAMPLE_BITS-1:0] audio;
      logic                          block_end;
   } audio_item_t;

   logic                     clock = 1'b0;
   logic                     reset;
   logic                     csr_psel;
   logic                     csr_penable;
   logic                     csr_pwrite;
   logic [CSR_ADDR_BITS-1:0] csr_paddr;
   logic [31:0]              csr_pwdata;
   logic [31:0]              csr_prdata;
   logic                     csr_pready;

   fpl_req_if #(.SAMPLE_BITS(SAMPLE_BITS)) req_if ();
   fpl_rsp_if #(.SAMPLE_BITS(SAMPLE_BITS)) rsp_if ();

   // register copies held by the filter model
   logic [17:0] stage_gain_m;
   logic [16:0] feedback_gain_m;
   logic [15:0] drive_gain_m;
   logic        hp_enable_m;
   logic [17:0] hp_gain_m;

   // filter model state, integrators in Q4.27, tanh table in Q1.23
   longint ladder_state [4];
   longint hp_state;
   longint tanh_table [CLIP_DEPTH];

   audio_item_t samples_to_send [$];
   audio_item_t expected_outputs [$];

   int unsigned send_idle_pct;
   int unsigned recv_idle_pct;
   bit          sample_taken = 1'b0;
   int          mismatches = 0;
   int          samples_accepted = 0;
   int          outputs_checked = 0;
   int          settings_applied = 0;
   int          idle_cycles = 0;

   four_pole_ladder_lowpass #(
      .SAMPLE_BITS      (SAMPLE_BITS),
      .CLIP_TABLE_DEPTH (CLIP_DEPTH)
   ) dut (
      .clock       (clock),
      .reset       (reset),
      .req_port    (req_if),
      .rsp_port    (rsp_if),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always begin
      #HALF_PERIOD clock = 1'b1;
      #HALF_PERIOD clock = 1'b0;
   end

   // ---------------------------------------------------------------- filter model

   function automatic longint clamp_q27(input longint v);
      if (v > Q27_MAX) begin
         return Q27_MAX;
      end else if (v < Q27_MIN) begin
         return Q27_MIN;
      end
      return v;
   endfunction

   // e to the minus f, f and result in Q.31, series to twenty terms
   function automatic longint exp_neg_frac(input longint f);
      longint sum;
      longint term;
      sum  = FRAC31_ONE;
      term = FRAC31_ONE;
      for (int k = 1; k <= 20; k++) begin
         term = ((term * f) >>> 31) / k;
         if (k % 2 == 1) begin
            sum -= term;
         end else begin
            sum += term;
         end
      end
      return sum;
   endfunction

   // entry i holds tanh(8i/depth) in Q1.23, built as (1-e^-2x)/(1+e^-2x)
   function automatic void build_tanh_table();
      longint e1;
      longint num;
      longint whole;
      longint f;
      longint e;
      longint t;
      e1 = exp_neg_frac(FRAC31_ONE);
      for (int i = 0; i < CLIP_DEPTH; i++) begin
         num   = 16 * i;
         whole = num / CLIP_DEPTH;
         f     = ((num % CLIP_DEPTH) <<< 31) / CLIP_DEPTH;
         e     = exp_neg_frac(f);
         for (longint j = 0; j < whole; j++) begin
            e = (e * e1) >>> 31;
         end
         t = (((FRAC31_ONE - e) <<< 23) + ((FRAC31_ONE + e) >>> 1)) / (FRAC31_ONE + e);
         if (t > longint'(CLIP_MAX)) begin
            t = longint'(CLIP_MAX);
         end
         tanh_table[i] = t;
      end
   endfunction

   // tanh lookup with linear interpolation, Q4.27 in and out
   function automatic longint soft_clip(input longint y);
      longint mag;
      longint pos;
      longint frac;
      longint lo;
      longint hi;
      longint r;
      int     idx;
      mag = (y < 0) ? -y : y;
      if (mag >= Q27_EIGHT) begin
         r = longint'(CLIP_MAX);
      end else begin
         // table spans 0 to 8, so the index is the top bits of mag times depth
         pos  = mag * CLIP_DEPTH;
         idx  = int'(pos >>> 30);
         frac = pos & (Q27_EIGHT - 1);
         lo   = tanh_table[idx];
         hi   = (idx + 1 < CLIP_DEPTH) ? tanh_table[idx + 1] : longint'(CLIP_MAX);
         r    = lo + (((hi - lo) * frac) >>> 30);
      end
      if (y < 0) begin
         r = -r;
      end
      return r * 16;
   endfunction

   // trapezoidal one-pole, returns the low-pass value and the new integrator
   function automatic longint one_pole(input longint in_v, input longint st, input longint g,
                                       output longint st_next);
      longint v;
      longint lp;
      v       = clamp_q27(((in_v - st) * g) >>> 18);
      lp      = clamp_q27(v + st);
      st_next = clamp_q27(lp + v);
      return lp;
   endfunction

   function automatic audio_item_t ladder_filter_step(input audio_item_t s);
      audio_item_t r;
      longint      x;
      longint      y;
      longint      u;
      longint      lp;
      longint      nxt;
      x = longint'($signed(s.audio)) <<< Q27_SHIFT;

      // optional high-pass pre-stage
      if (hp_enable_m) begin
         lp       = one_pole(x, hp_state, longint'(hp_gain_m), nxt);
         hp_state = nxt;
         x        = clamp_q27(x - lp);
      end

      // drive, with soft clip only above unity
      y = clamp_q27((x * longint'(drive_gain_m)) >>> 12);
      if (drive_gain_m > DRIVE_UNITY) begin
         y = soft_clip(y);
      end

      // resonance feedback and the four ladder poles
      u = clamp_q27(y - ((ladder_state[3] * longint'(feedback_gain_m)) >>> 15));
      for (int k = 0; k < 4; k++) begin
         u               = one_pole(u, ladder_state[k], longint'(stage_gain_m), nxt);
         ladder_state[k] = nxt;
      end

      // back to sample format, saturated
      y = u >>> Q27_SHIFT;
      if (y > SAMPLE_MAX) begin
         y = SAMPLE_MAX;
      end else if (y < SAMPLE_MIN) begin
         y = SAMPLE_MIN;
      end
      r.audio     = y[SAMPLE_BITS-1:0];
      r.block_end = s.block_end;
      return r;
   endfunction

   function automatic logic [31:0] register_value(input logic [2:0] sel);
      case (sel)
         REG_STAGE_GAIN:    return 32'(stage_gain_m);
         REG_FEEDBACK_GAIN: return 32'(feedback_gain_m);
         REG_DRIVE_GAIN:    return 32'(drive_gain_m);
         REG_HP_ENABLE:     return 32'(hp_enable_m);
         REG_HP_GAIN:       return 32'(hp_gain_m);
         default:           return '0;
      endcase
   endfunction

   function automatic void report_mismatch(input string what, input longint want,
                                           input longint got);
      if (mismatches < REPORT_LIMIT) begin
         $display("mismatch in %s: expected %0d, got %0d", what, want, got);
      end
      mismatches++;
   endfunction

   // ---------------------------------------------------------------- register port

   task automatic csr_write(input logic [2:0] sel, input logic [31:0] value);
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {sel, 2'b00};
      csr_pwdata  <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      // bits above each register width are dropped, unmapped slots ignored
      case (sel)
         REG_STAGE_GAIN:    stage_gain_m    = value[17:0];
         REG_FEEDBACK_GAIN: feedback_gain_m = value[16:0];
         REG_DRIVE_GAIN:    drive_gain_m    = value[15:0];
         REG_HP_ENABLE:     hp_enable_m     = value[0];
         REG_HP_GAIN:       hp_gain_m       = value[17:0];
         default: ;
      endcase
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   task automatic csr_read(input logic [2:0] sel, output logic [31:0] value);
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= {sel, 2'b00};
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      value = csr_prdata;
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   task automatic apply_settings(input logic [31:0] stage, input logic [31:0] fb,
                                 input logic [31:0] drive, input logic [31:0] hp_on,
                                 input logic [31:0] hp_g);
      logic [31:0] got;
      csr_write(REG_STAGE_GAIN, stage);
      csr_write(REG_FEEDBACK_GAIN, fb);
      csr_write(REG_DRIVE_GAIN, drive);
      csr_write(REG_HP_ENABLE, hp_on);
      csr_write(REG_HP_GAIN, hp_g);
      // a write past the register map must leave everything alone
      csr_write(3'($urandom_range(LAST_REG_SLOT, NUM_REGS)), $urandom());
      for (int i = 0; i < NUM_REGS; i++) begin
         csr_read(3'(i), got);
         if (got !== register_value(3'(i))) begin
            report_mismatch($sformatf("register %0d readback", i),
                            longint'(register_value(3'(i))), longint'(got));
         end
      end
      settings_applied++;
   endtask

   // ---------------------------------------------------------------- stimulus helpers

   function automatic void add_sample(input longint audio, input logic block_end);
      audio_item_t s;
      s.audio     = SAMPLE_BITS'(audio);
      s.block_end = block_end;
      samples_to_send.push_back(s);
   endfunction

   function automatic audio_item_t random_sample();
      audio_item_t s;
      case ($urandom_range(9))
         0: begin
            case ($urandom_range(3))
               0:       s.audio = SAMPLE_BITS'(SAMPLE_MAX);
               1:       s.audio = SAMPLE_BITS'(SAMPLE_MIN);
               2:       s.audio = '0;
               default: s.audio = '1;
            endcase
         end
         1, 2:    s.audio = SAMPLE_BITS'(int'($urandom_range(8191)) - 4096);
         default: s.audio = SAMPLE_BITS'($urandom());
      endcase
      s.block_end = ($urandom_range(15) == 0);
      return s;
   endfunction

   // register value, often an extreme, sometimes with junk above the width
   function automatic logic [31:0] random_field(input int width);
      logic [31:0] mask;
      logic [31:0] v;
      mask = (32'd1 << width) - 32'd1;
      case ($urandom_range(4))
         0:       v = '0;
         1:       v = mask;
         default: v = $urandom() & mask;
      endcase
      if ($urandom_range(1) == 1) begin
         v = v | ($urandom() & ~mask);
      end
      return v;
   endfunction

   task automatic wait_drained();
      while (samples_to_send.size() != 0 || req_if.valid || expected_outputs.size() != 0) begin
         @(posedge clock);
      end
   endtask

   task automatic settle();
      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // ---------------------------------------------------------------- sample driver

   always @(negedge clock) begin
      audio_item_t next_s;
      if (reset) begin
         req_if.valid <= 1'b0;
      end else if (!req_if.valid || sample_taken) begin
         if (samples_to_send.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            next_s = samples_to_send.pop_front();
            req_if.valid     <= 1'b1;
            req_if.audio_in  <= next_s.audio;
            req_if.block_end <= next_s.block_end;
         end else begin
            req_if.valid <= 1'b0;
         end
      end
      sample_taken = 1'b0;
      rsp_if.ready <= ($urandom_range(99) >= recv_idle_pct);
   end

   // ---------------------------------------------------------------- monitor and checker

   always @(posedge clock) begin
      audio_item_t got;
      audio_item_t want;
      bit          moved;
      moved = 1'b0;

      // accepted sample goes through the model
      if (!reset && req_if.valid && req_if.ready) begin
         got.audio     = req_if.audio_in;
         got.block_end = req_if.block_end;
         expected_outputs.push_back(ladder_filter_step(got));
         sample_taken = 1'b1;
         samples_accepted++;
         moved = 1'b1;
      end

      // accepted output against the oldest prediction
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         moved = 1'b1;
         outputs_checked++;
         if (expected_outputs.size() == 0) begin
            report_mismatch("output with nothing outstanding", 0,
                            longint'($signed(rsp_if.audio_out)));
         end else begin
            want = expected_outputs.pop_front();
            if (rsp_if.audio_out !== want.audio) begin
               report_mismatch($sformatf("audio_out of output %0d", outputs_checked),
                               longint'($signed(want.audio)),
                               longint'($signed(rsp_if.audio_out)));
            end
            if (rsp_if.block_end_out !== want.block_end) begin
               report_mismatch($sformatf("block_end_out of output %0d", outputs_checked),
                               longint'(want.block_end), longint'(rsp_if.block_end_out));
            end
         end
      end

      // watchdog on cycles with no item moving
      if (moved) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog: no item moved for %0d cycles", WATCHDOG_LIMIT);
         $display("tb: failure");
         $finish;
      end
   end

   // ---------------------------------------------------------------- test sequence

   initial begin
      logic [31:0] drive_w;

      reset             = 1'b1;
      csr_psel          = 1'b0;
      csr_penable       = 1'b0;
      csr_pwrite        = 1'b0;
      csr_paddr         = '0;
      csr_pwdata        = '0;
      req_if.valid      = 1'b0;
      req_if.audio_in   = '0;
      req_if.block_end  = 1'b0;
      rsp_if.ready      = 1'b0;
      send_idle_pct     = 19;
      recv_idle_pct     = 60;

      // model at reset
      build_tanh_table();
      stage_gain_m    = STAGE_GAIN_RESET;
      feedback_gain_m = FEEDBACK_GAIN_RESET;
      drive_gain_m    = DRIVE_GAIN_RESET;
      hp_enable_m     = 1'b0;
      hp_gain_m       = HP_GAIN_RESET;
      hp_state        = 0;
      for (int k = 0; k < 4; k++) begin
         ladder_state[k] = 0;
      end

      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset settings: zero ladder gain, so the output stays at zero
      add_sample(SAMPLE_MAX, 1'b0);
      add_sample(SAMPLE_MIN, 1'b1);
      settle();

      // every gain at full scale with junk above the widths, feedback near 4,
      // high-pass on with zero gain, drive far into the clip
      apply_settings(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                     32'hFFFC_0000);
      add_sample(SAMPLE_MAX, 1'b0);
      add_sample(SAMPLE_MAX, 1'b1);
      add_sample(SAMPLE_MIN, 1'b0);
      add_sample(SAMPLE_MIN, 1'b0);
      add_sample(0, 1'b1);
      add_sample(1, 1'b0);
      add_sample(-1, 1'b0);
      add_sample(SAMPLE_MAX, 1'b0);
      add_sample(0, 1'b1);
      settle();

      // drive just above unity: clip with interpolation over the low entries
      apply_settings(32'd8192, 32'd0, 32'(DRIVE_UNITY) + 32'd1, 32'd0, 32'd0);
      add_sample(SAMPLE_MAX, 1'b0);
      add_sample(4194304, 1'b0);
      add_sample(2097152, 1'b1);
      add_sample(-2097152, 1'b0);
      add_sample(1048576, 1'b0);
      add_sample(-1, 1'b0);
      add_sample(0, 1'b1);
      settle();

      // drive exactly unity, no clip; feedback 2.0; full high-pass gain
      apply_settings(32'd40000, 32'd65536, 32'(DRIVE_UNITY), 32'd1, 32'h3FFFF);
      add_sample(SAMPLE_MAX, 1'b0);
      add_sample(SAMPLE_MIN, 1'b0);
      add_sample(12345, 1'b1);
      add_sample(-12345, 1'b0);
      add_sample(SAMPLE_MAX, 1'b0);
      add_sample(SAMPLE_MAX, 1'b0);
      add_sample(SAMPLE_MIN, 1'b1);

      // random phases with fresh settings each time
      for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
         settle();
         case (ph / 2)
            0: begin
               send_idle_pct = 19;
               recv_idle_pct = 60;
            end
            1: begin
               send_idle_pct = 60;
               recv_idle_pct = 19;
            end
            default: begin
               send_idle_pct = 0;
               recv_idle_pct = 0;
            end
         endcase
         case ($urandom_range(3))
            0:       drive_w = 32'(DRIVE_UNITY);
            1:       drive_w = $urandom_range(4095);
            2:       drive_w = $urandom_range(65535, 4097);
            default: drive_w = random_field(16);
         endcase
         apply_settings(random_field(18), random_field(17), drive_w, random_field(1),
                        random_field(18));
         for (int n = 0; n < PHASE_SAMPLES; n++) begin
            // halfway through, hold back until every output is in
            if (n == PHASE_SAMPLES / 2) begin
               wait_drained();
            end
            samples_to_send.push_back(random_sample());
         end
      end
      settle();

      $display("summary: %0d samples filtered under %0d register settings, %0d outputs compared",
               samples_accepted, settings_applied, outputs_checked);
      $display("summary: reset, full-scale, unity and clipping drives, high-pass on and off");
      if (mismatches == 0 && expected_outputs.size() == 0) begin
         $display("tb: success");
      end else begin
         $display("summary: %0d mismatches, %0d outputs missing", mismatches,
                  expected_outputs.size());
         $display("tb: failure");
      end
      $finish;
   end

endmodule
